/* rtl/core/fftag_pkg.sv */
// Shared constants, codes and types of the boundary-tag heap allocator.
package fftag_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int IDX_W      = $clog2(HEAP_WORDS);
    localparam int HEAP_SPAN  = HEAP_WORDS * 4;
    localparam int SPAN_MIN   = 64;
    localparam int CNT_W      = IDX_W + 1;

    localparam int CFG_W   = 15;
    localparam int OP_W    = 2;
    localparam int REQ_W   = 14;
    localparam int BADDR_W = 14;
    localparam int RES_W   = 14;
    localparam int ST_W    = 3;
    localparam int WORD_W  = 32;

    localparam logic [WORD_W-1:0] TAG_ALLOC = 32'h1;
    localparam logic [WORD_W-1:0] SZ_MASK   = ~32'h3;
    localparam logic [WORD_W-1:0] HEAD_TAG  = 32'h11;
    localparam logic [WORD_W-1:0] FIRST_BP  = 32'd20;
    localparam logic [WORD_W-1:0] MIN_BLOCK = 32'd16;
    localparam logic [WORD_W-1:0] SPLIT_MIN = 32'd24;
    localparam logic [WORD_W-1:0] FMT_OVH   = 32'd40;
    localparam logic [3:0]        FMT_LAST  = 4'd10;

    typedef enum logic [OP_W-1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_VERIFY = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_ALREADY = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_VFAIL   = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE, S_FIN, S_FMT,
        S_AL_RL, S_AL_RH, S_AL_CHK, S_AL_RPV, S_AL_RNX, S_AL_W1, S_AL_W2,
        S_SP_1, S_SP_2, S_SP_3, S_SP_4, S_SP_5, S_SP_6, S_SP_7, S_SP_8,
        S_AL_RH2, S_AL_WH, S_AL_RF, S_AL_WF,
        S_FR_RH, S_FR_CHK, S_FR_RF, S_FR_WF, S_FR_RP, S_FR_PCHK, S_FR_PRH,
        S_FR_PT, S_FR_PPE, S_FR_PNE, S_FR_PW2, S_FR_RN, S_FR_NT, S_FR_NRH,
        S_FR_NCHK, S_FR_NNE, S_FR_NPE, S_FR_NW1, S_FR_NW2, S_FR_DEC,
        S_FI_RT, S_FI_CHK, S_FI_W1, S_FI_W2, S_FI_W3, S_FI_W4,
        S_FM_1, S_FM_2, S_FM_3, S_FM_4, S_FM_5, S_FM_6,
        S_VF_R4, S_VF_T, S_VF_C1, S_VF2_RH, S_VF2_C
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

    function automatic logic in_heap(input logic [WORD_W-1:0] a);
        return a[WORD_W-1:IDX_W+2] == '0;
    endfunction

endpackage

/* rtl/core/first_fit_boundary_tag_allocator_core.sv */
// Top level of the first-fit boundary-tag heap allocator.
//
// Commands enter on start while busy is low: operation, request_bytes and
// block_address are taken at that edge. The block then raises busy and runs
// the operation against its 4096-word heap memory, one memory access per
// cycle on the single memory port. When done it shows result_address and
// status for exactly one cycle with o_done high, then drops busy the next
// cycle. The receiver cannot hold results off.
// Allocate walks the free list for the first block that fits; free merges
// with a free neighbor, or else the block is linked into the free list by
// address; verify walks the free list and then the heap blocks. The next
// command is taken in the cycle after the result at the earliest, and the
// free-list walk over the one memory port sets how long a command runs.
// Heap span comes from the configuration register (write enable and data,
// reset value 16384 bytes); write it only while idle (block does not check).
// Reset clears the formatted flag and returns the span register to 16384;
// the heap memory itself is not cleared and is laid out by the format command.
module first_fit_boundary_tag_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [fftag_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [fftag_pkg::OP_W-1:0]    i_operation,
    input  logic [fftag_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [fftag_pkg::BADDR_W-1:0] i_block_address,
    output logic                          o_done,
    output logic [fftag_pkg::RES_W-1:0]   o_result_address,
    output logic [fftag_pkg::ST_W-1:0]    o_status
);
    import fftag_pkg::*;

    logic [CFG_W-1:0]  r_heap_bytes;
    logic [CFG_W-1:0]  span;
    logic [WORD_W-1:0] ram_q;
    t_mem_req          mem_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= CFG_W'(HEAP_SPAN);
        end else if (i_cfg_we) begin
            r_heap_bytes <= i_cfg_wdata;
        end
    end

    // clamp the span to at least 64 bytes and at most the physical heap
    always_comb begin
        span = r_heap_bytes;
        if (r_heap_bytes < CFG_W'(SPAN_MIN)) begin
            span = CFG_W'(SPAN_MIN);
        end else if (r_heap_bytes > CFG_W'(HEAP_SPAN)) begin
            span = CFG_W'(HEAP_SPAN);
        end
    end

    fftag_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (start && !busy),
        .i_op             (i_operation),
        .i_req            (i_request_bytes),
        .i_bp             (i_block_address),
        .i_span           (span),
        .i_rdata          (ram_q),
        .o_mem            (mem_req),
        .o_busy           (busy),
        .o_done           (o_done),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

    fftag_ram #(
        .DEPTH  (HEAP_WORDS),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.idx),
        .i_wdata (mem_req.wdata),
        .o_rdata (ram_q)
    );
endmodule

/* rtl/core/fftag_alu.sv */
// Add/subtract unit shared by every heap address and some pointer steps.
module fftag_alu (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_y
);
    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);
endmodule

/* rtl/core/fftag_ram.sv */
// Single-port heap word memory with registered read data.
module fftag_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule

/* rtl/core/fftag_seq.sv */
// Operation sequencer: walks the heap one memory access per step.
module fftag_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [fftag_pkg::OP_W-1:0]    i_op,
    input  logic [fftag_pkg::REQ_W-1:0]   i_req,
    input  logic [fftag_pkg::BADDR_W-1:0] i_bp,
    input  logic [fftag_pkg::CFG_W-1:0]   i_span,
    input  logic [fftag_pkg::WORD_W-1:0]  i_rdata,
    output fftag_pkg::t_mem_req           o_mem,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [fftag_pkg::RES_W-1:0]   o_result_address,
    output logic [fftag_pkg::ST_W-1:0]    o_status
);
    import fftag_pkg::*;

    t_state            r_state, n_state;
    logic              r_formatted, n_formatted;
    logic              r_rd_ok;
    logic [3:0]        r_step, n_step;
    logic [15:0]       r_req, n_req;
    logic [31:0]       r_bp, n_bp, r_t, n_t, r_tn, n_tn, r_found, n_found;
    logic [31:0]       r_bsz, n_bsz, r_pv, n_pv, r_nx, n_nx, r_nb, n_nb;
    logic [31:0]       r_f, n_f, r_total, n_total, r_start, n_start, r_res, n_res;
    logic [CNT_W-1:0]  r_n, n_n;
    t_status           r_status, n_status;

    logic [31:0] alu_a, alu_b, alu_y, wdata;
    logic        alu_sub, wr, rd;
    logic [31:0] rdat, rsz, req32, rem, span32, fsz, eb, rq;
    logic [CNT_W-1:0] n_inc;
    logic        over;

    fftag_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    assign rdat   = r_rd_ok ? i_rdata : '0;
    assign rsz    = rdat & SZ_MASK;
    assign req32  = {16'b0, r_req};
    assign rem    = r_bsz - req32;
    assign span32 = {{(32-CFG_W){1'b0}}, i_span};
    assign fsz    = (span32 - FMT_OVH) & SZ_MASK;
    assign eb     = fsz + FIRST_BP;
    assign n_inc  = r_n + 1'b1;
    assign over   = n_inc > CNT_W'(HEAP_WORDS);
    assign rq     = ((({18'b0, i_req}) + 32'd3) & SZ_MASK) + 32'd8;

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_formatted = r_formatted;
        n_step      = r_step;
        n_req       = r_req;
        n_bp        = r_bp;
        n_t         = r_t;
        n_tn        = r_tn;
        n_found     = r_found;
        n_bsz       = r_bsz;
        n_pv        = r_pv;
        n_nx        = r_nx;
        n_nb        = r_nb;
        n_f         = r_f;
        n_total     = r_total;
        n_start     = r_start;
        n_res       = r_res;
        n_n         = r_n;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_res    = '0;
                    n_status = ST_OK;
                    n_n      = '0;
                    n_step   = '0;
                    n_req    = (rq < MIN_BLOCK) ? MIN_BLOCK[15:0] : rq[15:0];
                    n_bp     = {18'b0, i_bp[BADDR_W-1:2], 2'b00};
                    n_t      = 32'd4;
                    if (t_op'(i_op) == OP_FORMAT) begin
                        if (r_formatted) begin
                            n_status = ST_ALREADY;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_FMT;
                        end
                    end else if (!r_formatted) begin
                        n_status = ST_IGNORED;
                        n_state  = S_FIN;
                    end else begin
                        case (t_op'(i_op))
                            OP_ALLOC: n_state = S_AL_RL;
                            OP_FREE:  n_state = S_FR_RH;
                            default:  n_state = S_VF_R4;
                        endcase
                    end
                end
            end
            S_FIN: n_state = S_IDLE;
            S_FMT: begin
                n_step = r_step + 1'b1;
                if (r_step == FMT_LAST) begin
                    n_formatted = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_AL_RL: n_state = S_AL_RH;
            S_AL_RH: begin
                n_t     = rdat;
                n_state = S_AL_CHK;
            end
            S_AL_CHK: begin
                n_n = n_inc;
                if (rsz == '0 || over) begin
                    n_status = ST_NOFIT;
                    n_state  = S_FIN;
                end else if (rsz >= req32) begin
                    n_found = r_t;
                    n_bsz   = rsz;
                    if (rdat[0]) begin
                        n_status = ST_NOFIT;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_AL_RPV;
                    end
                end else begin
                    n_state = S_AL_RH;
                end
            end
            S_AL_RPV: n_state = S_AL_RNX;
            S_AL_RNX: begin
                n_pv    = rdat;
                n_state = S_AL_W1;
            end
            S_AL_W1: begin
                n_nx    = rdat;
                n_state = S_AL_W2;
            end
            S_AL_W2: begin
                n_nb    = r_found + req32;
                n_state = (rem >= SPLIT_MIN) ? S_SP_1 : S_AL_RH2;
            end
            S_SP_1: n_state = S_SP_2;
            S_SP_2: n_state = S_SP_3;
            S_SP_3: begin
                n_f     = r_nb - 32'd8 + (in_heap(r_nb - 32'd4) ? rem : '0);
                n_state = S_SP_4;
            end
            S_SP_4: n_state = S_SP_5;
            S_SP_5: n_state = S_SP_6;
            S_SP_6: n_state = S_SP_7;
            S_SP_7: n_state = S_SP_8;
            S_SP_8: begin
                n_res   = r_found;
                n_state = S_FIN;
            end
            S_AL_RH2: n_state = S_AL_WH;
            S_AL_WH: begin
                n_f     = r_found - 32'd8 + rsz;
                n_state = S_AL_RF;
            end
            S_AL_RF: n_state = S_AL_WF;
            S_AL_WF: begin
                n_res   = r_found;
                n_state = S_FIN;
            end
            S_FR_RH: n_state = S_FR_CHK;
            S_FR_CHK: begin
                if (!rdat[0]) begin
                    n_status = ST_IGNORED;
                    n_state  = S_FIN;
                end else begin
                    n_total = rsz;
                    n_start = r_bp;
                    n_pv    = '0;
                    n_nx    = '0;
                    n_f     = r_bp - 32'd8 + rsz;
                    n_state = S_FR_RF;
                end
            end
            S_FR_RF: n_state = S_FR_WF;
            S_FR_WF: n_state = S_FR_RP;
            S_FR_RP: n_state = S_FR_PCHK;
            S_FR_PCHK: begin
                if (rdat[0]) begin
                    n_state = S_FR_RN;
                end else begin
                    n_t     = alu_y;
                    n_start = alu_y;
                    n_state = S_FR_PRH;
                end
            end
            S_FR_PRH: n_state = S_FR_PT;
            S_FR_PT: begin
                n_total = r_total + rsz;
                n_state = S_FR_PPE;
            end
            S_FR_PPE: begin
                n_pv    = rdat;
                n_state = S_FR_PNE;
            end
            S_FR_PNE: begin
                n_nx    = rdat;
                n_state = S_FR_PW2;
            end
            S_FR_PW2: n_state = S_FR_RN;
            S_FR_RN:  n_state = S_FR_NT;
            S_FR_NT: begin
                n_t     = alu_y;
                n_state = S_FR_NRH;
            end
            S_FR_NRH: n_state = S_FR_NCHK;
            S_FR_NCHK: begin
                if (rdat[0]) begin
                    n_state = S_FR_DEC;
                end else begin
                    n_total = r_total + rsz;
                    n_state = S_FR_NNE;
                end
            end
            S_FR_NNE: begin
                n_nx    = rdat;
                n_state = (r_pv == '0) ? S_FR_NPE : S_FR_NW1;
            end
            S_FR_NPE: begin
                n_pv    = rdat;
                n_state = S_FR_NW1;
            end
            S_FR_NW1: n_state = S_FR_NW2;
            S_FR_NW2: n_state = S_FR_DEC;
            S_FR_DEC: begin
                if (r_pv == '0) begin
                    n_t     = 32'd4;
                    n_n     = '0;
                    n_state = S_FI_RT;
                end else begin
                    n_state = S_FM_1;
                end
            end
            S_FI_RT: n_state = S_FI_CHK;
            S_FI_CHK: begin
                n_n = n_inc;
                if (rdat == '0 || over) begin
                    n_state = S_FIN;
                end else if (r_t < r_bp && r_bp < rdat) begin
                    n_tn    = rdat;
                    n_state = S_FI_W1;
                end else begin
                    n_t     = rdat;
                    n_state = S_FI_RT;
                end
            end
            S_FI_W1: n_state = S_FI_W2;
            S_FI_W2: n_state = S_FI_W3;
            S_FI_W3: n_state = S_FI_W4;
            S_FI_W4: n_state = S_FIN;
            S_FM_1: begin
                n_f = r_start - 32'd8
                    + (in_heap(r_start - 32'd4) ? (r_total & SZ_MASK) : '0);
                n_state = S_FM_2;
            end
            S_FM_2: n_state = S_FM_3;
            S_FM_3: n_state = S_FM_4;
            S_FM_4: n_state = S_FM_5;
            S_FM_5: n_state = S_FM_6;
            S_FM_6: n_state = S_FIN;
            S_VF_R4: n_state = S_VF_T;
            S_VF_T: begin
                n_t     = rdat;
                n_state = S_VF_C1;
            end
            S_VF_C1: begin
                if (rsz == '0) begin
                    n_t     = 32'd4;
                    n_n     = '0;
                    n_state = S_VF2_RH;
                end else if (over || rdat[0] || r_t > span32) begin
                    n_status = ST_VFAIL;
                    n_state  = S_FIN;
                end else begin
                    n_n     = n_inc;
                    n_state = S_VF_T;
                end
            end
            S_VF2_RH: n_state = S_VF2_C;
            S_VF2_C: begin
                if (rsz == '0) begin
                    n_state = S_FIN;
                end else if (over || r_t > span32) begin
                    n_status = ST_VFAIL;
                    n_state  = S_FIN;
                end else begin
                    n_n     = n_inc;
                    n_t     = alu_y;
                    n_state = S_VF2_RH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory access and shared-unit operands for each step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        wr      = 1'b0;
        rd      = 1'b0;
        wdata   = '0;
        unique case (r_state)
            S_FMT: begin
                wr = 1'b1;
                case (r_step)
                    4'd0:  begin alu_b = 32'd0;  wdata = HEAD_TAG; end
                    4'd1:  begin alu_b = 32'd12; wdata = HEAD_TAG; end
                    4'd2:  begin alu_b = 32'd16; wdata = fsz; end
                    4'd3:  begin alu_a = fsz; alu_b = 32'd12; wdata = fsz; end
                    4'd4:  begin alu_a = fsz; alu_b = 32'd16; wdata = TAG_ALLOC; end
                    4'd5:  begin alu_b = 32'd4;  wdata = FIRST_BP; end
                    4'd6:  begin alu_b = 32'd8;  wdata = '0; end
                    4'd7:  begin alu_b = 32'd20; wdata = eb; end
                    4'd8:  begin alu_b = 32'd24; wdata = 32'd4; end
                    4'd9:  begin alu_a = fsz; alu_b = 32'd20; wdata = '0; end
                    4'd10: begin alu_a = fsz; alu_b = 32'd24; wdata = FIRST_BP; end
                    default: wr = 1'b0;
                endcase
            end
            S_AL_RL: begin rd = 1'b1; alu_a = r_t; end
            S_AL_RH: begin rd = 1'b1; alu_a = rdat; alu_b = 32'd4; alu_sub = 1'b1; end
            S_AL_CHK: begin
                // keep walking: fetch the next list link
                rd    = (rsz != '0) && !over && (rsz < req32);
                alu_a = r_t;
            end
            S_AL_RPV: begin rd = 1'b1; alu_a = r_found; alu_b = 32'd4; end
            S_AL_RNX: begin rd = 1'b1; alu_a = r_found; end
            S_AL_W1:  begin wr = 1'b1; alu_a = r_pv; wdata = rdat; end
            S_AL_W2:  begin wr = 1'b1; alu_a = r_nx; alu_b = 32'd4; wdata = r_pv; end
            S_SP_1: begin
                wr = 1'b1; alu_a = r_found; alu_b = 32'd4; alu_sub = 1'b1;
                wdata = req32 | TAG_ALLOC;
            end
            S_SP_2: begin
                wr = 1'b1; alu_a = r_nb; alu_b = 32'd8; alu_sub = 1'b1;
                wdata = req32 | TAG_ALLOC;
            end
            S_SP_3: begin
                wr = 1'b1; alu_a = r_nb; alu_b = 32'd4; alu_sub = 1'b1; wdata = rem;
            end
            S_SP_4: begin wr = 1'b1; alu_a = r_f; wdata = rem; end
            S_SP_5: begin wr = 1'b1; alu_a = r_pv; wdata = r_nb; end
            S_SP_6: begin wr = 1'b1; alu_a = r_nx; alu_b = 32'd4; wdata = r_nb; end
            S_SP_7: begin wr = 1'b1; alu_a = r_nb; wdata = r_nx; end
            S_SP_8: begin wr = 1'b1; alu_a = r_nb; alu_b = 32'd4; wdata = r_pv; end
            S_AL_RH2: begin
                rd = 1'b1; alu_a = r_found; alu_b = 32'd4; alu_sub = 1'b1;
            end
            S_AL_WH: begin
                wr = 1'b1; alu_a = r_found; alu_b = 32'd4; alu_sub = 1'b1;
                wdata = rdat | TAG_ALLOC;
            end
            S_AL_RF: begin rd = 1'b1; alu_a = r_f; end
            S_AL_WF: begin wr = 1'b1; alu_a = r_f; wdata = rdat | TAG_ALLOC; end
            S_FR_RH: begin rd = 1'b1; alu_a = r_bp; alu_b = 32'd4; alu_sub = 1'b1; end
            S_FR_CHK: begin
                wr = rdat[0]; alu_a = r_bp; alu_b = 32'd4; alu_sub = 1'b1;
                wdata = rdat & ~TAG_ALLOC;
            end
            S_FR_RF: begin rd = 1'b1; alu_a = r_f; end
            S_FR_WF: begin wr = 1'b1; alu_a = r_f; wdata = rdat & ~TAG_ALLOC; end
            S_FR_RP: begin rd = 1'b1; alu_a = r_bp; alu_b = 32'd8; alu_sub = 1'b1; end
            S_FR_PCHK: begin alu_a = r_bp; alu_b = rsz; alu_sub = 1'b1; end
            S_FR_PRH: begin rd = 1'b1; alu_a = r_t; alu_b = 32'd4; alu_sub = 1'b1; end
            S_FR_PT:  begin rd = 1'b1; alu_a = r_t; alu_b = 32'd4; end
            S_FR_PPE: begin rd = 1'b1; alu_a = r_t; end
            S_FR_PNE: begin wr = 1'b1; alu_a = r_pv; wdata = rdat; end
            S_FR_PW2: begin wr = 1'b1; alu_a = r_nx; alu_b = 32'd4; wdata = r_pv; end
            S_FR_RN:  begin rd = 1'b1; alu_a = r_bp; alu_b = 32'd4; alu_sub = 1'b1; end
            S_FR_NT:  begin alu_a = r_bp; alu_b = rsz; end
            S_FR_NRH: begin rd = 1'b1; alu_a = r_t; alu_b = 32'd4; alu_sub = 1'b1; end
            S_FR_NCHK: begin rd = !rdat[0]; alu_a = r_t; end
            S_FR_NNE: begin rd = (r_pv == '0); alu_a = r_t; alu_b = 32'd4; end
            S_FR_NW1: begin wr = 1'b1; alu_a = r_nx; alu_b = 32'd4; wdata = r_pv; end
            S_FR_NW2: begin wr = 1'b1; alu_a = r_pv; wdata = r_nx; end
            S_FI_RT:  begin rd = 1'b1; alu_a = r_t; end
            S_FI_W1:  begin wr = 1'b1; alu_a = r_t; wdata = r_bp; end
            S_FI_W2:  begin wr = 1'b1; alu_a = r_tn; alu_b = 32'd4; wdata = r_bp; end
            S_FI_W3:  begin wr = 1'b1; alu_a = r_bp; alu_b = 32'd4; wdata = r_t; end
            S_FI_W4:  begin wr = 1'b1; alu_a = r_bp; wdata = r_tn; end
            S_FM_1: begin
                wr = 1'b1; alu_a = r_start; alu_b = 32'd4; alu_sub = 1'b1;
                wdata = r_total & SZ_MASK;
            end
            S_FM_2: begin wr = 1'b1; alu_a = r_f; wdata = r_total & SZ_MASK; end
            S_FM_3: begin wr = 1'b1; alu_a = r_nx; alu_b = 32'd4; wdata = r_start; end
            S_FM_4: begin wr = 1'b1; alu_a = r_pv; wdata = r_start; end
            S_FM_5: begin wr = 1'b1; alu_a = r_start; wdata = r_nx; end
            S_FM_6: begin wr = 1'b1; alu_a = r_start; alu_b = 32'd4; wdata = r_pv; end
            S_VF_R4: begin rd = 1'b1; alu_a = r_t; end
            S_VF_T:  begin rd = 1'b1; alu_a = rdat; alu_b = 32'd4; alu_sub = 1'b1; end
            S_VF_C1: begin
                rd    = (rsz != '0) && !over && !rdat[0] && (r_t <= span32);
                alu_a = r_t;
            end
            S_VF2_RH: begin rd = 1'b1; alu_a = r_t; alu_b = 32'd4; alu_sub = 1'b1; end
            S_VF2_C:  begin alu_a = r_t; alu_b = rsz; end
            default: begin
                rd = 1'b0;
            end
        endcase
    end

    // drop accesses outside the heap; such reads return zero
    assign o_mem.we    = wr && in_heap(alu_y);
    assign o_mem.re    = rd && in_heap(alu_y);
    assign o_mem.idx   = alu_y[IDX_W+1:2];
    assign o_mem.wdata = wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_formatted <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_formatted <= n_formatted;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= in_heap(alu_y);
        r_step  <= n_step;
        r_req   <= n_req;
        r_bp    <= n_bp;
        r_t     <= n_t;
        r_tn    <= n_tn;
        r_found <= n_found;
        r_bsz   <= n_bsz;
        r_pv    <= n_pv;
        r_nx    <= n_nx;
        r_nb    <= n_nb;
        r_f     <= n_f;
        r_total <= n_total;
        r_start <= n_start;
        r_res   <= n_res;
        r_n     <= n_n;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = (r_state == S_FIN);
    assign o_result_address = r_res[RES_W-1:0];
    assign o_status         = r_status;
endmodule

/* rtl/core/fftag_chk.sv */
// Port-level checker for the allocator core and its bind.
module fftag_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [fftag_pkg::ST_W-1:0]  o_status,
    input logic [fftag_pkg::RES_W-1:0] o_result_address
);
    import fftag_pkg::*;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_result_address == '0))
        else $error("failed command returned an address");
endmodule

bind first_fit_boundary_tag_allocator_core fftag_chk u_fftag_chk (.*);

/* tb/tb.sv */
// Self-checking testbench for the first-fit boundary-tag heap allocator core.
`timescale 1ns / 1ps

module tb;
    import fftag_pkg::*;

    localparam int      CYCLE_LIMIT = 1500000;
    localparam int      LIVE_MAX    = 48;
    localparam int      MISMATCH_SHOWN = 10;
    localparam int      RANDOM_ITEMS   = 1000;
    localparam int      CFG_ZERO    = 0;
    localparam int      CFG_FLOOR   = 64;
    localparam int      CFG_MID     = 1000;
    localparam int      CFG_FULL    = 16384;
    localparam int      CFG_ALLONES = 32767;

    typedef struct {
        t_op                op;
        logic [REQ_W-1:0]   req;
        logic [BADDR_W-1:0] baddr;
    } t_cmd;

    typedef struct {
        logic [RES_W-1:0] addr;
        t_status          st;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic [OP_W-1:0]      i_operation = '0;
    logic [REQ_W-1:0]     i_request_bytes = '0;
    logic [BADDR_W-1:0]   i_block_address = '0;
    logic                 o_done;
    logic [RES_W-1:0]     o_result_address;
    logic [ST_W-1:0]      o_status;

    first_fit_boundary_tag_allocator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_block_address  (i_block_address),
        .o_done           (o_done),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

    // Shadow heap and allocator state
    logic [31:0]  heap_img [HEAP_WORDS];
    bit           heap_ready;
    logic [31:0]  span_reg;

    t_cmd         cmd_q [$];
    t_answer      answer_q [$];
    logic [31:0]  live_blocks [$];
    logic [31:0]  last_freed;
    bit           last_freed_ok;

    int           idle_pct;
    int           cycles;
    int           mismatches;
    int           transfers;
    int           n_alloc_ok;
    int           n_nofit;
    int           n_freed;
    int           n_vfail;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] hrd(logic [31:0] a);
        logic [31:0] i;
        i = a >> 2;
        return (i < HEAP_WORDS) ? heap_img[i] : 32'd0;
    endfunction

    function automatic void hwr(logic [31:0] a, logic [31:0] v);
        logic [31:0] i;
        i = a >> 2;
        if (i < HEAP_WORDS) heap_img[i] = v;
    endfunction

    function automatic logic [31:0] bsize(logic [31:0] a);
        return hrd(a) & ~32'd3;
    endfunction

    function automatic logic [31:0] footer_of(logic [31:0] bp);
        return bp - 32'd8 + bsize(bp - 32'd4);
    endfunction

    function automatic logic [31:0] next_block(logic [31:0] bp);
        return bp + bsize(bp - 32'd4);
    endfunction

    function automatic logic [31:0] eff_span();
        logic [31:0] s;
        s = span_reg;
        if (s < 32'd64) s = 32'd64;
        if (s > HEAP_WORDS * 4) s = HEAP_WORDS * 4;
        return s;
    endfunction

    function automatic void lay_out_heap();
        logic [31:0] fsz, eb;
        fsz = (eff_span() - 32'd40) & ~32'd3;
        hwr(32'd0, 32'h11);
        hwr(32'd12, 32'h11);
        hwr(32'd16, fsz);
        hwr(footer_of(32'd20), fsz);
        eb = next_block(32'd20);
        hwr(eb - 32'd4, 32'd1);
        hwr(32'd4, 32'd20);
        hwr(32'd8, 32'd0);
        hwr(32'd20, eb);
        hwr(32'd24, 32'd4);
        hwr(eb, 32'd0);
        hwr(eb + 32'd4, 32'd20);
        heap_ready = 1'b1;
    endfunction

    function automatic logic [31:0] take_first_fit(logic [31:0] nbytes);
        logic [31:0] want, lst, found, n, bsz, pv, nx, nb, rem, f;
        want = ((nbytes + 32'd3) & ~32'd3) + 32'd8;
        lst = 32'd4;
        found = 0;
        n = 0;
        if (want < 32'd16) want = 32'd16;
        while (bsize(hrd(lst) - 32'd4) != 0) begin
            n++;
            if (n > HEAP_WORDS) return 0;
            if (bsize(hrd(lst) - 32'd4) >= want) begin
                found = hrd(lst);
                break;
            end
            lst = hrd(lst);
        end
        if (found == 0) return 0;
        bsz = bsize(found - 32'd4);
        if (bsz < want || (hrd(found - 32'd4) & 32'd1) != 0) return 0;
        pv = hrd(found + 32'd4);
        nx = hrd(found);
        hwr(pv, nx);
        hwr(nx + 32'd4, pv);
        if (bsz - want >= 32'd24) begin
            nb = found + want;
            rem = bsz - want;
            hwr(found - 32'd4, want | 32'd1);
            hwr(footer_of(found), want | 32'd1);
            hwr(nb - 32'd4, rem);
            hwr(footer_of(nb), rem);
            hwr(pv, nb);
            hwr(nx + 32'd4, nb);
            hwr(nb, nx);
            hwr(nb + 32'd4, pv);
        end else begin
            f = footer_of(found);
            hwr(found - 32'd4, hrd(found - 32'd4) | 32'd1);
            hwr(f, hrd(f) | 32'd1);
        end
        return found;
    endfunction

    function automatic void give_back(logic [31:0] bp);
        logic [31:0] total, first, pe, ne, t, f, tn, n, v;
        total = bsize(bp - 32'd4);
        first = bp;
        pe = 0;
        ne = 0;
        hwr(bp - 32'd4, hrd(bp - 32'd4) & ~32'd1);
        f = footer_of(bp);
        hwr(f, hrd(f) & ~32'd1);
        // merge with the block below
        if ((hrd(bp - 32'd8) & 32'd1) == 0) begin
            t = bp - bsize(bp - 32'd8);
            first = t;
            total += bsize(t - 32'd4);
            pe = hrd(t + 32'd4);
            ne = hrd(t);
            hwr(pe, ne);
            hwr(ne + 32'd4, pe);
        end
        // merge with the block above
        t = next_block(bp);
        if ((hrd(t - 32'd4) & 32'd1) == 0) begin
            total += bsize(t - 32'd4);
            ne = hrd(t);
            if (pe == 0) pe = hrd(t + 32'd4);
            hwr(ne + 32'd4, pe);
            hwr(pe, ne);
        end
        if (pe == 0) begin
            n = 0;
            t = 32'd4;
            while (hrd(t) != 0) begin
                n++;
                if (n > HEAP_WORDS) break;
                tn = hrd(t);
                if (t < bp && bp < tn) begin
                    hwr(t, bp);
                    hwr(tn + 32'd4, bp);
                    hwr(bp + 32'd4, t);
                    hwr(bp, tn);
                    break;
                end
                t = tn;
            end
        end else begin
            v = total & ~32'd3;
            hwr(first - 32'd4, v);
            hwr(footer_of(first), v);
            hwr(ne + 32'd4, first);
            hwr(pe, first);
            hwr(first, ne);
            hwr(first + 32'd4, pe);
        end
    endfunction

    function automatic bit heap_consistent();
        logic [31:0] lim, t, n;
        lim = eff_span();
        t = hrd(32'd4);
        n = 0;
        while (bsize(t - 32'd4) != 0) begin
            n++;
            if (n > HEAP_WORDS || (hrd(t - 32'd4) & 32'd1) != 0 || t > lim) return 1'b0;
            t = hrd(t);
        end
        t = 32'd4;
        n = 0;
        while (bsize(t - 32'd4) != 0) begin
            n++;
            if (n > HEAP_WORDS || t > lim) return 1'b0;
            t = next_block(t);
        end
        return 1'b1;
    endfunction

    function automatic t_answer predict_answer(t_cmd c);
        t_answer     r;
        logic [31:0] bp, a;
        bp = {18'd0, c.baddr & 14'h3FFC};
        r.addr = '0;
        r.st = ST_OK;
        if (c.op == OP_FORMAT) begin
            if (heap_ready) r.st = ST_ALREADY;
            else lay_out_heap();
        end else if (!heap_ready) begin
            r.st = ST_IGNORED;
        end else if (c.op == OP_ALLOC) begin
            a = take_first_fit({18'd0, c.req});
            r.addr = a[RES_W-1:0];
            if (a == 0) r.st = ST_NOFIT;
        end else if (c.op == OP_FREE) begin
            if ((hrd(bp - 32'd4) & 32'd1) != 0) give_back(bp);
            else r.st = ST_IGNORED;
        end else if (!heap_consistent()) begin
            r.st = ST_VFAIL;
        end
        return r;
    endfunction

    // Predict at queue time; commands run strictly in order
    task automatic queue_cmd(t_op op, int req, int baddr);
        t_cmd    c;
        t_answer r;
        c.op = op;
        c.req = req[REQ_W-1:0];
        c.baddr = baddr[BADDR_W-1:0];
        r = predict_answer(c);
        last_freed_ok = 1'b0;
        if (op == OP_ALLOC && r.st == ST_OK) begin
            live_blocks.push_back({18'd0, r.addr});
            n_alloc_ok++;
        end
        if (op == OP_ALLOC && r.st == ST_NOFIT) n_nofit++;
        if (op == OP_FREE && r.st == ST_OK) begin
            n_freed++;
            last_freed = {18'd0, c.baddr & 14'h3FFC};
            last_freed_ok = 1'b1;
        end
        if (op == OP_VERIFY && r.st == ST_VFAIL) n_vfail++;
        cmd_q.push_back(c);
        answer_q.push_back(r);
    endtask

    task automatic free_live(int k, int low_bits);
        logic [31:0] a;
        a = live_blocks[k];
        live_blocks.delete(k);
        queue_cmd(OP_FREE, $urandom, a | low_bits);
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || answer_q.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_span(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        span_reg = v & 32'h7FFF;
        @(negedge i_clk);
    endtask

    task automatic random_cmds(int count);
        int r, k;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                queue_cmd(OP_FORMAT, $urandom, $urandom);
            end else if (r < 50 && live_blocks.size() < LIVE_MAX || live_blocks.size() == 0)
            begin
                if ($urandom_range(19) == 0) k = $urandom_range(16383);
                else if ($urandom_range(9) == 0) k = $urandom_range(2000);
                else k = $urandom_range(120);
                queue_cmd(OP_ALLOC, k, $urandom);
            end else if (r < 90) begin
                if (last_freed_ok && $urandom_range(9) == 0)
                    queue_cmd(OP_FREE, $urandom, last_freed | $urandom_range(3));
                else
                    free_live($urandom_range(live_blocks.size() - 1), $urandom_range(3));
            end else begin
                queue_cmd(OP_VERIFY, $urandom, $urandom);
            end
        end
    endtask

    // Command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                void'(cmd_q.pop_front());
            end
            if (start && busy) begin
                // hold until taken
            end else if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_operation <= cmd_q[0].op;
                i_request_bytes <= cmd_q[0].req;
                i_block_address <= cmd_q[0].baddr;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_answer e;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            transfers <= transfers + 1;
            if (answer_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MISMATCH_SHOWN)
                    $display("unexpected result transfer: addr %0d status %0d",
                             o_result_address, o_status);
            end else begin
                e = answer_q.pop_front();
                if (o_result_address !== e.addr || o_status !== e.st) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MISMATCH_SHOWN)
                        $display("mismatch: addr exp %0d got %0d, status exp %0d got %0d",
                                 e.addr, o_result_address, e.st, o_status);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int a1;
        cycles = 0;
        mismatches = 0;
        transfers = 0;
        idle_pct = 0;
        heap_ready = 1'b0;
        span_reg = CFG_FULL;
        last_freed_ok = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unformatted heap refuses everything but format
        queue_cmd(OP_ALLOC, 0, 0);
        queue_cmd(OP_FREE, 0, 16383);
        queue_cmd(OP_VERIFY, 16383, 0);
        drain();
        write_span(CFG_ALLONES);
        queue_cmd(OP_FORMAT, 16383, 16383);
        queue_cmd(OP_FORMAT, 0, 0);
        queue_cmd(OP_ALLOC, 0, 0);
        queue_cmd(OP_ALLOC, 5, 0);
        queue_cmd(OP_ALLOC, 12, 0);
        queue_cmd(OP_ALLOC, 16383, 0);
        queue_cmd(OP_ALLOC, 9000, 0);
        queue_cmd(OP_VERIFY, 0, 0);
        a1 = live_blocks[1];
        free_live(1, 0);
        queue_cmd(OP_FREE, 0, a1);
        free_live(0, 3);
        queue_cmd(OP_ALLOC, 100, 0);
        free_live(0, 1);
        queue_cmd(OP_VERIFY, 0, 0);
        drain();
        write_span(CFG_FLOOR);
        queue_cmd(OP_VERIFY, 0, 0);
        drain();
        write_span(CFG_ZERO);
        queue_cmd(OP_VERIFY, 0, 0);
        drain();
        write_span(CFG_FULL);

        idle_pct = 0;
        random_cmds(RANDOM_ITEMS / 4);
        drain();
        idle_pct = 73;
        random_cmds(RANDOM_ITEMS / 4);
        drain();
        write_span(CFG_MID);
        idle_pct = 0;
        random_cmds(RANDOM_ITEMS / 4);
        drain();
        write_span(CFG_FULL);
        idle_pct = 32;
        random_cmds(RANDOM_ITEMS / 4);
        drain();
        repeat (20) @(negedge i_clk);

        $display("covered %0d result transfers: %0d allocations, %0d no-fit, %0d frees",
                 transfers, n_alloc_ok, n_nofit, n_freed);
        $display("verify failures predicted %0d, mismatches %0d", n_vfail, mismatches);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
